// ----- rtl/md5_pkg.sv -----
// MD5 stream hash package: round constants, shift amounts, message index,
// initial chaining value and the controller/datapath command and status types.
// No dependencies.
`default_nettype none
package md5_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0]  PAD_MARK = 8'h80;
	localparam logic [5:0]  LEN_POS = 6'd56;

	localparam logic [31:0] ROUND_ADD [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_AMT [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	// message word used by round r
	function automatic logic [3:0] msg_index(input logic [5:0] r);
		logic [3:0] g;
		case (r[5:4])
			2'd0: g = r[3:0];
			2'd1: g = 4'(5 * r[3:0] + 1);
			2'd2: g = 4'(3 * r[3:0] + 5);
			default: g = 4'(7 * r[3:0]);
		endcase
		return g;
	endfunction

	// byte source for a write into the block buffer
	typedef enum logic [1:0] {
		SRC_DATA, SRC_MARK, SRC_ZERO, SRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic      wr_en;       // write one byte at wr_addr
		byte_src_t wr_src;
		logic [5:0] wr_addr;
		logic      cnt_inc;     // bump bit count by eight
		logic      len_latch;   // freeze bit count for the length field
		logic      word_load;   // load message word from buffer read data
		logic [5:0] rd_addr;
		logic      rnd_start;   // copy chain into working regs
		logic      rnd_step;    // one round, index rnd
		logic [5:0] rnd;
		logic      chain_add;   // fold working regs into chain
		logic      chain_init;  // back to IV, count to zero
		logic [1:0] out_sel;
	} md5_cmd_t;

	typedef struct packed {
		logic [5:0] fill_pos;   // byte position from the bit count
	} md5_stat_t;

endpackage
`default_nettype wire

// ----- rtl/md5_stream_hash.sv -----
// MD5 stream hash top level: ties the controller to the datapath.
// Depends on md5_pkg, md5_ctrl, md5_dp, md5_ram.
//
// channel  direction  handshake            payload
// in       to block   valid_in/ready_in    data_byte, byte_present, end_of_message
// out      from block valid_out/ready_out  digest_word, word_number, last_word
//
// A byte that does not fill the block is taken without leaving idle. A filled
// block is unloaded from the buffer, then runs 64 rounds, one round a cycle
// through the single round unit, and one fold. A message end adds a padding sweep
// from the fill position up to byte 63 and one or two compressions; a block
// filled by the last byte is compressed first and then a whole padding block
// follows. Four digest words then wait for ready_out; ready_in stays low from
// a block fill to its fold, and from a message end to the last digest word.
// Reset restores the IV and clears the bit count.
`default_nettype none
module md5_stream_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid_in,
	output logic             ready_in,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_present,
	input  wire logic        end_of_message,
	output logic             valid_out,
	input  wire logic        ready_out,
	output logic [31:0]      digest_word,
	output logic [1:0]       word_number,
	output logic             last_word
);
	import md5_pkg::*;

	md5_cmd_t  cmd;
	md5_stat_t stat;

	md5_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.valid_in(valid_in), .ready_in(ready_in),
		.byte_present(byte_present), .end_of_message(end_of_message),
		.valid_out(valid_out), .ready_out(ready_out),
		.word_number(word_number), .last_word(last_word),
		.stat(stat), .cmd(cmd)
	);

	md5_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .data_byte(data_byte),
		.stat(stat), .digest_word(digest_word)
	);
endmodule
`default_nettype wire

// ----- rtl/md5_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module md5_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/md5_dp.sv -----
// MD5 datapath: block buffer, bit count, message word registers, round unit,
// chaining words. Depends on md5_pkg and md5_ram.
`default_nettype none
module md5_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire md5_pkg::md5_cmd_t cmd,
	input  wire logic [7:0]       data_byte,
	output md5_pkg::md5_stat_t    stat,
	output logic [31:0]           digest_word
);
	import md5_pkg::*;

	logic [63:0] bits_q, len_q;
	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] m_q [16];
	logic [7:0]  wdata, rdata;
	logic [31:0] sum, f, rot_in;
	logic [4:0]  sh;
	logic [3:0]  g;

	always_comb begin
		case (cmd.wr_src)
			SRC_DATA: wdata = data_byte;
			SRC_MARK: wdata = PAD_MARK;
			SRC_ZERO: wdata = 8'h00;
			default:  wdata = len_q[{cmd.wr_addr[2:0], 3'b000} +: 8];
		endcase
	end

	md5_ram #(.Width(8), .Depth(64)) u_buf (
		.clk(clk), .we(cmd.wr_en), .waddr(cmd.wr_addr), .wdata(wdata),
		.raddr(cmd.rd_addr), .rdata(rdata)
	);

	assign stat.fill_pos = bits_q[8:3];

	always_comb begin
		case (cmd.rnd[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		g = msg_index(cmd.rnd);
		sh = ROT_AMT[{cmd.rnd[5:4], cmd.rnd[1:0]}];
		rot_in = a_q + f + ROUND_ADD[cmd.rnd] + m_q[g];
		sum = b_q + ((rot_in << sh) | (rot_in >> (6'd32 - {1'b0, sh})));
	end

	assign digest_word = chain_q[cmd.out_sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			chain_q <= '{IV_A, IV_B, IV_C, IV_D};
		end else begin
			if (cmd.chain_init) begin
				bits_q <= '0;
				chain_q <= '{IV_A, IV_B, IV_C, IV_D};
			end else begin
				if (cmd.cnt_inc) bits_q <= bits_q + 64'd8;
				if (cmd.chain_add) begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.len_latch) len_q <= bits_q;
		// read data arrives the cycle after rd_addr; controller delays word_load
		if (cmd.word_load) begin
			m_q[cmd.rd_addr[5:2] - 4'(cmd.rd_addr[1:0] == 2'd0)]
				[{2'(cmd.rd_addr[1:0] - 2'd1), 3'b000} +: 8] <= rdata;
		end
		if (cmd.rnd_start) begin
			a_q <= chain_q[0]; b_q <= chain_q[1];
			c_q <= chain_q[2]; d_q <= chain_q[3];
		end else if (cmd.rnd_step) begin
			a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= sum;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/md5_ctrl.sv -----
// MD5 controller: input/output handshakes, padding sequence, buffer unload,
// round sequencing. Depends on md5_pkg.
`default_nettype none
module md5_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_in,
	output logic                   ready_in,
	input  wire logic              byte_present,
	input  wire logic              end_of_message,
	output logic                   valid_out,
	input  wire logic              ready_out,
	output logic [1:0]             word_number,
	output logic                   last_word,
	input  wire md5_pkg::md5_stat_t stat,
	output md5_pkg::md5_cmd_t      cmd
);
	import md5_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_OUT
	} state_t;

	state_t     state_q;
	logic [5:0] pos_q;      // pad write address
	logic [6:0] cnt_q;      // load byte counter, 0..64
	logic [5:0] rnd_q;
	logic       final_q;    // compression belongs to the finishing sequence
	logic       padnext_q;  // after this compression, pad a fresh block
	logic       pad_done_q; // padding already written for the current message
	logic [1:0] wsel_q;
	logic       acc;

	assign ready_in = (state_q == ST_IDLE);
	assign acc = valid_in && ready_in;
	assign valid_out = (state_q == ST_OUT);
	assign word_number = wsel_q;
	assign last_word = (wsel_q == 2'd3);

	always_comb begin
		cmd = '0;
		cmd.wr_src = SRC_DATA;
		cmd.rnd = rnd_q;
		cmd.out_sel = wsel_q;
		cmd.rd_addr = cnt_q[5:0];
		case (state_q)
			ST_IDLE: begin
				cmd.wr_addr = stat.fill_pos;
				cmd.wr_en = acc && byte_present;
				cmd.cnt_inc = acc && byte_present;
			end
			ST_PAD: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = pos_q;
				// length goes into the last padding block only
				if (pos_q == stat.fill_pos && !padnext_q) cmd.wr_src = SRC_MARK;
				else if (pos_q >= LEN_POS && (padnext_q || stat.fill_pos < LEN_POS))
					cmd.wr_src = SRC_LEN;
				else cmd.wr_src = SRC_ZERO;
			end
			ST_LOAD: begin
				cmd.word_load = (cnt_q != 7'd0);
				cmd.rnd_start = (cnt_q == 7'd64);
			end
			ST_ROUND: cmd.rnd_step = 1'b1;
			ST_ADD:   cmd.chain_add = 1'b1;
			ST_OUT:   cmd.chain_init = ready_out && (wsel_q == 2'd3);
			default:  ;
		endcase
		// bit count is final and stable for the whole padding sweep
		cmd.len_latch = (state_q == ST_PAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			cnt_q <= '0;
			rnd_q <= '0;
			final_q <= 1'b0;
			padnext_q <= 1'b0;
			wsel_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						cnt_q <= '0;
						final_q <= end_of_message;
						padnext_q <= 1'b0;
						if (byte_present && stat.fill_pos == 6'd63) begin
							state_q <= ST_LOAD;
						end else if (end_of_message) begin
							// fill position after this byte
							pos_q <= byte_present ? stat.fill_pos + 6'd1 : stat.fill_pos;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// the mark goes where the count points; padnext skips it
					pos_q <= pos_q + 6'd1;
					if (pos_q == 6'd63) begin
						cnt_q <= '0;
						// mark at >= 56 means length needs a second block
						padnext_q <= !padnext_q && stat.fill_pos >= LEN_POS;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd64) begin
						rnd_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (padnext_q) begin
						pos_q <= '0;
						state_q <= ST_PAD;
					end else if (final_q && !pad_done_q) begin
						// a full block that also ends the message still needs padding
						pos_q <= '0;
						state_q <= ST_PAD;
					end else if (final_q) begin
						wsel_q <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (ready_out) begin
						wsel_q <= wsel_q + 2'd1;
						if (wsel_q == 2'd3) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pad_done_q <= 1'b0;
		else if (state_q == ST_IDLE) pad_done_q <= 1'b0;
		else if (state_q == ST_PAD) pad_done_q <= 1'b1;
	end
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for md5_stream_hash: random and directed messages checked against an
// in-bench MD5 digest predictor. Depends on md5_stream_hash and its package.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        valid_in = 1'b0;
	logic        ready_in;
	logic [7:0]  data_byte = '0;
	logic        byte_present = 1'b0;
	logic        end_of_message = 1'b0;
	logic        valid_out;
	logic        ready_out = 1'b0;
	logic [31:0] digest_word;
	logic [1:0]  word_number;
	logic        last_word;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       eom;
	} in_word_t;

	typedef struct packed {
		logic [31:0] dword;
		logic [1:0]  num;
		logic        last;
	} digest_out_t;

	in_word_t    pending_words[$];
	digest_out_t expected_digest[$];
	bit          failed = 1'b0;
	bit          stim_done = 1'b0;

	md5_stream_hash dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [31:0] chain[4];
	logic [7:0]  blk[64];
	logic [63:0] msg_bits;

	localparam logic [31:0] K_TAB [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int SHIFT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
		6, 10, 15, 21};

	function automatic void reset_chain();
		chain[0] = 32'h67452301;
		chain[1] = 32'hefcdab89;
		chain[2] = 32'h98badcfe;
		chain[3] = 32'h10325476;
		msg_bits = '0;
	endfunction

	function automatic void compress_block();
		logic [31:0] m[16];
		logic [31:0] a, b, c, d, f, t, s;
		int g, sh;
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		for (int i = 0; i < 16; i++)
			m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				f = (b & c) | (~b & d); g = r;
			end else if (r < 32) begin
				f = (d & b) | (~d & c); g = (5*r + 1) % 16;
			end else if (r < 48) begin
				f = b ^ c ^ d; g = (3*r + 5) % 16;
			end else begin
				f = c ^ (b | ~d); g = (7*r) % 16;
			end
			sh = SHIFT_TAB[(r/16)*4 + r%4];
			s = a + f + K_TAB[r] + m[g];
			t = d; d = c; c = b;
			b = b + ((s << sh) | (s >> (32 - sh)));
			a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
	endfunction

	// absorb one word; on end of message, pad, finish and queue four digest words
	function automatic void predict_digest(in_word_t w);
		int pos;
		logic [63:0] len;
		if (w.present) begin
			pos = msg_bits[8:3];
			blk[pos] = w.data;
			msg_bits += 64'd8;
			if (pos == 63) compress_block();
		end
		if (!w.eom) return;
		len = msg_bits;
		pos = len[8:3];
		blk[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			while (pos < 64) blk[pos++] = 8'h00;
			compress_block();
			pos = 0;
		end
		while (pos < 56) blk[pos++] = 8'h00;
		for (int k = 0; k < 8; k++) blk[56+k] = len[8*k +: 8];
		compress_block();
		for (int k = 0; k < 4; k++)
			expected_digest.push_back('{chain[k], 2'(k), k == 3});
		reset_chain();
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic void push_msg(int nbytes, bit end_empty);
		for (int i = 0; i < nbytes; i++)
			pending_words.push_back('{8'($urandom), 1'b1,
				!end_empty && i == nbytes - 1});
		if (end_empty || nbytes == 0)
			pending_words.push_back('{8'($urandom), 1'b0, 1'b1});
	endfunction

	// driver: one word presented at a time, held until taken
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (valid_in && ready_in) begin
				predict_digest('{data_byte, byte_present, end_of_message});
				in_gap = gap_len();
			end
			if (!valid_in || ready_in) begin
				if (in_gap == 0 && pending_words.size() > 0) begin
					in_word_t w;
					w = pending_words.pop_front();
					valid_in <= 1'b1;
					data_byte <= w.data;
					byte_present <= w.present;
					end_of_message <= w.eom;
				end else begin
					valid_in <= 1'b0;
					if (in_gap > 0) in_gap--;
				end
			end
		end
	end

	// monitor: compare each digest word with the oldest expectation
	int out_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (valid_out && ready_out) begin
				if (expected_digest.size() == 0) begin
					$display("%0t: unexpected digest word %h", $time, digest_word);
					failed = 1'b1;
				end else begin
					digest_out_t e;
					e = expected_digest.pop_front();
					if (e.dword !== digest_word) begin
						$display("%0t: digest_word exp %h got %h", $time, e.dword, digest_word);
						failed = 1'b1;
					end
					if (e.num !== word_number) begin
						$display("%0t: word_number exp %0d got %0d", $time, e.num, word_number);
						failed = 1'b1;
					end
					if (e.last !== last_word) begin
						$display("%0t: last_word exp %0d got %0d", $time, e.last, last_word);
						failed = 1'b1;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				ready_out <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				out_gap = gap_len();
				ready_out <= 1'b0;
			end else
				ready_out <= 1'b1;
		end
	end

	initial begin
		reset_chain();
		// directed: empty message, two bytes and an idle word then bare end, a one-byte
		// message, 55/56/63/64 byte boundaries, extreme byte values
		push_msg(0, 1'b1);
		pending_words.push_back('{8'h00, 1'b1, 1'b0});
		pending_words.push_back('{8'hff, 1'b1, 1'b0});
		pending_words.push_back('{8'h00, 1'b0, 1'b0});
		pending_words.push_back('{8'h5a, 1'b0, 1'b1});
		pending_words.push_back('{8'hff, 1'b1, 1'b1});
		push_msg(55, 1'b0);
		push_msg(56, 1'b1);
		push_msg(63, 1'b0);
		push_msg(64, 1'b1);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// random: short messages, some with idle non-byte words and bare ends
		for (int n = 0; n < 10; n++) begin
			int len;
			len = $urandom_range(0, 12);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 7) == 0)
					pending_words.push_back('{8'($urandom), 1'b0, 1'b0});
				pending_words.push_back('{8'($urandom), 1'b1, 1'b0});
			end
			if ($urandom_range(0, 1))
				pending_words.push_back('{8'($urandom), 1'b0, 1'b1});
			else
				pending_words.push_back('{8'($urandom), 1'b1, 1'b1});
		end
		wait (pending_words.size() == 0 && !valid_in);
		wait (expected_digest.size() == 0);
		repeat (300) @(posedge clk);
		if (!failed && expected_digest.size() == 0)
			$display("[md5_stream_hash] OK");
		else
			$display("[md5_stream_hash] ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("[md5_stream_hash] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/md5_pkg.sv
rtl/md5_ram.sv
rtl/md5_dp.sv
rtl/md5_ctrl.sv
rtl/md5_stream_hash.sv
tb/tb_top.sv
